### sv/idb_pkg.sv
// Shared types and codes for the indexed deque buffer.
package idb_pkg;

  // Default sizing
  localparam int DEPTH_DEF      = 16;
  localparam int ELEM_WIDTH_DEF = 32;

  // Fixed field widths on the stream ports
  localparam int OP_W    = 4;
  localparam int POS_W   = 5;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  // Request codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 4'd0,
    OP_PUSH_FRONT = 4'd1,
    OP_INSERT     = 4'd2,
    OP_REPLACE    = 4'd3,
    OP_READ       = 4'd4,
    OP_POP_BACK   = 4'd5,
    OP_POP_FRONT  = 4'd6,
    OP_REMOVE     = 4'd7,
    OP_CLEAR      = 4'd8
  } op_t;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // Per-cell update select, one per cell in the chain
  typedef struct packed {
    logic load;        // take the request word
    logic from_left;   // take lower neighbor (gap opens)
    logic from_right;  // take upper neighbor (gap closes)
  } cell_ctl_t;

endpackage

### sv/indexed_deque_buffer.sv
// Indexed deque buffer: bounded ordered list built as a chain of word cells.
//
// Requests enter on the s_* stream; each accepted beat carries an opcode
// (push back/front, insert, replace, read, pop back/front, remove, clear),
// a logical position and a data word. Every request yields exactly one
// result beat on the m_* stream: the read or removed word (else zero), the
// element count after the request, and a status (ok, full, empty, index
// out of range). A refused request leaves the list unchanged.
// Inserts and removals shift all affected cells by one place in the same
// cycle, so the result is presented in the cycle after acceptance and one
// request can be taken per cycle while the receiver does not stall.
// The result sits in an output register; while the receiver stalls
// (m_tready low with m_tvalid high) s_tready drops and no request is taken.
// Reset clears the element count and the output valid; cell contents are
// not cleared and are only ever read below the count.
module indexed_deque_buffer
  import idb_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // opcode[3:0], position[8:4], data_word[40:9], zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // read_word[31:0], element_count[36:32], status[38:37], zero
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int MAXW = (ELEM_WIDTH > WORD_W) ? ELEM_WIDTH : WORD_W;

  logic                  fire;
  op_t                   op;
  logic [POS_W-1:0]      pos;
  logic [WORD_W-1:0]     data_word;
  logic [ELEM_WIDTH-1:0] load_word;
  cell_ctl_t             cell_ctl [DEPTH];
  logic [ELEM_WIDTH-1:0] words [DEPTH];
  logic [IW-1:0]         rd_idx;
  logic                  rd_en;
  logic [STAT_W-1:0]     status;
  logic [CW-1:0]         count_next;
  logic [MAXW-1:0]       rd_ext;
  logic [WORD_W-1:0]     read_word;

  // Unpack request beat
  assign op        = op_t'(s_tdata[3:0]);
  assign pos       = s_tdata[8:4];
  assign data_word = s_tdata[40:9];
  assign load_word = ELEM_WIDTH'(data_word);

  // No beat is taken while in reset
  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign fire     = s_tvalid && s_tready;

  idb_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .op         (op),
    .pos        (pos),
    .cell_ctl   (cell_ctl),
    .rd_idx     (rd_idx),
    .rd_en      (rd_en),
    .status     (status),
    .count_next (count_next)
  );

  // Cell chain, each cell linked to both neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left_word;
    logic [ELEM_WIDTH-1:0] right_word;
    if (i == 0) begin : g_lo
      assign left_word = '0;
    end else begin : g_lo
      assign left_word = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi
      assign right_word = '0;
    end else begin : g_hi
      assign right_word = words[i+1];
    end
    idb_cell #(
      .ELEM_WIDTH (ELEM_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .load_word  (load_word),
      .left_word  (left_word),
      .right_word (right_word),
      .word       (words[i])
    );
  end

  // Word returned by read, pops and remove
  assign rd_ext    = MAXW'(words[rd_idx]);
  assign read_word = rd_en ? rd_ext[WORD_W-1:0] : '0;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {1'b0, status, COUNT_W'(count_next), read_word};
    end
  end

endmodule

### sv/idb_cell.sv
// One storage cell of the element chain.
module idb_cell
  import idb_pkg::*;
#(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [ELEM_WIDTH-1:0] load_word,
  input  logic [ELEM_WIDTH-1:0] left_word,
  input  logic [ELEM_WIDTH-1:0] right_word,
  output logic [ELEM_WIDTH-1:0] word
);

  logic [ELEM_WIDTH-1:0] word_next;

  // Select the new content; hold otherwise
  always_comb begin
    if (ctl.load) begin
      word_next = load_word;
    end else if (ctl.from_left) begin
      word_next = left_word;
    end else if (ctl.from_right) begin
      word_next = right_word;
    end else begin
      word_next = word;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

### sv/idb_ctrl.sv
// Request decode, status checks, fill count and per-cell shift control.
module idb_ctrl
  import idb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  op_t                        op,
  input  logic [POS_W-1:0]           pos,
  output cell_ctl_t                  cell_ctl [DEPTH],
  output logic [$clog2(DEPTH)-1:0]   rd_idx,
  output logic                       rd_en,
  output logic [STAT_W-1:0]          status,
  output logic [$clog2(DEPTH+1)-1:0] count_next
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]   count;
  logic [CMPW-1:0] cnt_x;
  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] at;
  logic            full;
  logic            empty;
  logic            do_open;
  logic            do_close;
  logic            do_write;
  logic            do_read;
  logic            do_clear;

  assign cnt_x = CMPW'(count);
  assign pos_x = CMPW'(pos);
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // Decode: target index, status and action
  always_comb begin
    at       = '0;
    status   = ST_OK;
    do_open  = 1'b0;
    do_close = 1'b0;
    do_write = 1'b0;
    do_read  = 1'b0;
    do_clear = 1'b0;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
        if (op == OP_PUSH_BACK) begin
          at = cnt_x;
        end else if (op == OP_INSERT) begin
          at = pos_x;
        end
        if (full) begin
          status = ST_FULL;
        end else if (at > cnt_x) begin
          status = ST_RANGE;
        end else begin
          do_open = 1'b1;
        end
      end
      OP_REPLACE, OP_READ, OP_POP_BACK, OP_POP_FRONT, OP_REMOVE: begin
        if (op == OP_POP_BACK) begin
          at = cnt_x - CMPW'(1);
        end else if (op != OP_POP_FRONT) begin
          at = pos_x;
        end
        if (empty) begin
          status = ST_EMPTY;
        end else if (at >= cnt_x) begin
          status = ST_RANGE;
        end else if (op == OP_REPLACE) begin
          do_write = 1'b1;
        end else if (op == OP_READ) begin
          do_read = 1'b1;
        end else begin
          do_close = 1'b1;
        end
      end
      OP_CLEAR: begin
        do_clear = 1'b1;
      end
      default: begin
        // unused codes: no effect
      end
    endcase
  end

  // Count after this request
  always_comb begin
    if (do_clear) begin
      count_next = '0;
    end else if (do_open) begin
      count_next = count + CW'(1);
    end else if (do_close) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
  end

  assign rd_idx = at[IW-1:0];
  assign rd_en  = do_read || do_close;

  // Each cell compares its own index with the target and the fill count
  for (genvar i = 0; i < DEPTH; i++) begin : g_ctl
    always_comb begin
      cell_ctl[i].load       = fire && (do_open || do_write) && (at == CMPW'(i));
      cell_ctl[i].from_left  = fire && do_open && (CMPW'(i) > at) && (CMPW'(i) <= cnt_x);
      cell_ctl[i].from_right = fire && do_close && (CMPW'(i) >= at)
                               && ((CMPW'(i) + CMPW'(1)) < cnt_x);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

endmodule
